>>> rtl/position_pnl_tracker_defines.svh
// ----------------------------------------------------------------------------
// position_pnl_tracker_defines
// Assertion macros shared by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef POSITION_PNL_TRACKER_DEFINES_SVH
`define POSITION_PNL_TRACKER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("position_pnl_tracker: check failed");

// next-cycle implication
`define PPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("position_pnl_tracker: check failed");

`endif

>>> rtl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Types, codes and saturating helpers for the position / PnL tracker.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam logic [1:0] CMD_BAR  = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_FILL = 2'd2;

    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [47:0] OC_MAX    = 48'hFFFF_FFFF_FFFF;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic        start;
        logic [63:0] num_hi;
        logic [63:0] num_lo;
        logic [63:0] den;
    } ppt_div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quot;
    } ppt_div_rsp_t;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? S64_MIN : S64_MAX;
        return s;
    endfunction

    function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
            return a[63] ? S64_MIN : S64_MAX;
        return s;
    endfunction

endpackage

>>> rtl/position_pnl_tracker.sv
// ----------------------------------------------------------------------------
// position_pnl_tracker
// A bar updates peak equity and, when it is positive, runs a drawdown divide;
// a fill with both legs runs three divides on the shared radix-2 divider.
// Throughput: one item at a time; in_stall drops once the beat is loaded into the
// result register, so the next item can go in as soon as out_valid rises.
// Reset: cash and peak equity load 1000000000, other architectural state clears;
// the per-item working and result registers have no reset.
// ----------------------------------------------------------------------------
`include "position_pnl_tracker_defines.svh"

module position_pnl_tracker
#(
    parameter int QTY_BITS     = 24,
    parameter int PRICE_BITS   = 32,
    parameter int DD_FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [39:0]             cfg_data,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              command,
    input  logic [PRICE_BITS-1:0]   price,
    input  logic [QTY_BITS-1:0]     quantity,
    input  logic                    side,
    input  logic [23:0]             commission,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [63:0]      equity,
    output logic signed [63:0]      cash_now,
    output logic signed [31:0]      position_now,
    output logic [31:0]             entry_price,
    output logic signed [63:0]      realised_pnl,
    output logic                    trade_closed,
    output logic [DD_FRAC_BITS-1:0] drawdown_max,
    output logic [31:0]             wins,
    output logic [31:0]             closed_trades,
    output logic [31:0]             bars_in_position,
    output logic [31:0]             bars_total
);
    import ppt_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DEC  = 5'd1;
    localparam logic [4:0] S_CG   = 5'd2;
    localparam logic [4:0] S_CG2  = 5'd3;
    localparam logic [4:0] S_CCD  = 5'd4;
    localparam logic [4:0] S_CCW  = 5'd5;
    localparam logic [4:0] S_SH1  = 5'd6;
    localparam logic [4:0] S_SH2  = 5'd7;
    localparam logic [4:0] S_SHD  = 5'd8;
    localparam logic [4:0] S_SHW  = 5'd9;
    localparam logic [4:0] S_CF   = 5'd10;
    localparam logic [4:0] S_CU1  = 5'd11;
    localparam logic [4:0] S_CU2  = 5'd12;
    localparam logic [4:0] S_O0   = 5'd13;
    localparam logic [4:0] S_O1   = 5'd14;
    localparam logic [4:0] S_O2   = 5'd15;
    localparam logic [4:0] S_ODW  = 5'd16;
    localparam logic [4:0] S_OC   = 5'd17;
    localparam logic [4:0] S_EQ   = 5'd18;
    localparam logic [4:0] S_EQ2  = 5'd19;
    localparam logic [4:0] S_PK   = 5'd20;
    localparam logic [4:0] S_PK2  = 5'd21;
    localparam logic [4:0] S_DDW  = 5'd22;
    localparam logic [4:0] S_DONE = 5'd23;

    localparam logic [39:0] INIT_CASH = 40'd1000000000;
    localparam logic [63:0] DD_LIM    = (64'd1 << DD_FRAC_BITS) - 64'd1;

    logic [4:0] state_reg, state_next;

    // architectural state
    logic signed [63:0] cash_reg, cash_next;
    logic signed [31:0] pos_reg, pos_next;
    logic [31:0]        avg_reg, avg_next;
    logic [47:0]        oc_reg, oc_next;
    logic [31:0]        last_reg, last_next;
    logic signed [63:0] peak_reg, peak_next;
    logic [DD_FRAC_BITS-1:0] dd_reg, dd_next;
    logic [31:0]        wins_reg, wins_next;
    logic [31:0]        trades_reg, trades_next;
    logic [31:0]        held_reg, held_next;
    logic [31:0]        seen_reg, seen_next;

    // per-item working registers
    logic [1:0]         cmd_reg, cmd_next;
    logic [31:0]        px_reg, px_next;
    logic [31:0]        qty_reg, qty_next;
    logic               sell_reg, sell_next;
    logic [23:0]        comm_reg, comm_next;
    logic [31:0]        left_reg, left_next;
    logic [31:0]        cq_reg, cq_next;
    logic [31:0]        oq_reg, oq_next;
    logic [31:0]        pabs_reg, pabs_next;
    logic [23:0]        cc_reg, cc_next;
    logic [47:0]        share_reg, share_next;
    logic [63:0]        acc_reg, acc_next;
    logic signed [63:0] gross_reg, gross_next;
    logic signed [63:0] net_reg, net_next;
    logic signed [63:0] eq_reg, eq_next;
    logic signed [63:0] pnl_reg, pnl_next;
    logic               closed_reg, closed_next;

    // result register
    logic               ov_reg, ov_next;
    logic signed [63:0] o_eq_reg, o_cash_reg, o_pnl_reg;
    logic signed [31:0] o_pos_reg;
    logic [31:0]        o_avg_reg, o_wins_reg, o_trades_reg, o_held_reg, o_seen_reg;
    logic               o_closed_reg;
    logic [DD_FRAC_BITS-1:0] o_dd_reg;
    logic               o_load;

    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    ppt_div_req_t       div_req;
    ppt_div_rsp_t       div_rsp;

    ppt_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    ppt_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    logic               in_acc;
    logic               cfg_acc;
    logic [31:0]        pos_abs;
    logic [32:0]        diff;
    logic [31:0]        diff_abs;
    logic [31:0]        room;
    logic signed [63:0] p_signed;
    logic signed [63:0] flow_s;
    logic [23:0]        oc_add;
    logic [48:0]        oc_sum;
    logic [127:0]       sh_num;
    logic [63:0]        drop;
    logic signed [31:0] pos_step;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_acc   = cfg_valid && cfg_ready;

    assign pos_abs  = pos_reg[31] ? 32'(-pos_reg) : 32'(pos_reg);
    assign diff     = {1'b0, px_reg} - {1'b0, avg_reg};
    assign diff_abs = diff[32] ? 32'(-diff) : diff[31:0];
    assign room     = POS_LIMIT - pos_abs;
    assign p_signed = $signed(mul_p);
    assign flow_s   = sell_reg ? p_signed : -p_signed;
    assign oc_add   = comm_reg - cc_reg;
    assign oc_sum   = {1'b0, oc_reg} + {25'd0, oc_add};
    assign sh_num   = {32'd0, mul_p, 32'd0} + {64'd0, acc_reg};
    assign drop     = 64'(peak_reg) - 64'(eq_reg);
    assign o_load   = !ov_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        cash_next   = cash_reg;
        pos_next    = pos_reg;
        avg_next    = avg_reg;
        oc_next     = oc_reg;
        last_next   = last_reg;
        peak_next   = peak_reg;
        dd_next     = dd_reg;
        wins_next   = wins_reg;
        trades_next = trades_reg;
        held_next   = held_reg;
        seen_next   = seen_reg;
        cmd_next    = cmd_reg;
        px_next     = px_reg;
        qty_next    = qty_reg;
        sell_next   = sell_reg;
        comm_next   = comm_reg;
        left_next   = left_reg;
        cq_next     = cq_reg;
        oq_next     = oq_reg;
        pabs_next   = pabs_reg;
        cc_next     = cc_reg;
        share_next  = share_reg;
        acc_next    = acc_reg;
        gross_next  = gross_reg;
        net_next    = net_reg;
        eq_next     = eq_reg;
        pnl_next    = pnl_reg;
        closed_next = closed_reg;
        ov_next     = ov_reg && out_stall;
        mul_a       = '0;
        mul_b       = '0;
        div_req     = '0;
        pos_step    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_acc)
                begin
                    cash_next = $signed({24'd0, cfg_data});
                    peak_next = $signed({24'd0, cfg_data});
                end
                if (in_acc)
                begin
                    cmd_next    = command;
                    px_next     = 32'(price);
                    qty_next    = 32'(quantity);
                    sell_next   = side;
                    comm_next   = commission;
                    left_next   = 32'(quantity);
                    cc_next     = '0;
                    pnl_next    = '0;
                    closed_next = 1'b0;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_EQ;
                case (cmd_reg)
                    CMD_BAR:
                    begin
                        last_next = px_reg;
                        seen_next = seen_reg + 32'd1;
                        if (pos_reg != 0)
                            held_next = held_reg + 32'd1;
                    end
                    CMD_TICK:
                        last_next = px_reg;
                    CMD_FILL:
                    begin
                        if (qty_reg != 0)
                        begin
                            if ((pos_reg > 0 && sell_reg) || (pos_reg < 0 && !sell_reg))
                            begin
                                pabs_next  = pos_abs;
                                cq_next    = (pos_abs < qty_reg) ? pos_abs : qty_reg;
                                state_next = S_CG;
                            end
                            else
                                state_next = S_O0;
                        end
                    end
                    default: ;
                endcase
            end
            // closing leg
            S_CG:
            begin
                mul_a      = diff_abs;
                mul_b      = cq_reg;
                state_next = S_CG2;
            end
            S_CG2:
            begin
                gross_next = (diff[32] ^ pos_reg[31]) ? -p_signed : p_signed;
                mul_a      = 32'(comm_reg);
                mul_b      = cq_reg;
                state_next = S_CCD;
            end
            S_CCD:
            begin
                div_req.start  = 1'b1;
                div_req.num_hi = '0;
                div_req.num_lo = mul_p;
                div_req.den    = 64'(qty_reg);
                state_next     = S_CCW;
            end
            S_CCW:
            begin
                if (div_rsp.done)
                begin
                    cc_next    = div_rsp.quot[23:0];
                    state_next = S_SH1;
                end
            end
            S_SH1:
            begin
                mul_a      = oc_reg[31:0];
                mul_b      = cq_reg;
                state_next = S_SH2;
            end
            S_SH2:
            begin
                acc_next   = mul_p;
                mul_a      = {16'd0, oc_reg[47:32]};
                mul_b      = cq_reg;
                state_next = S_SHD;
            end
            S_SHD:
            begin
                div_req.start  = 1'b1;
                div_req.num_hi = sh_num[127:64];
                div_req.num_lo = sh_num[63:0];
                div_req.den    = 64'(pabs_reg);
                state_next     = S_SHW;
            end
            S_SHW:
            begin
                if (div_rsp.done)
                begin
                    share_next = div_rsp.quot[47:0];
                    state_next = S_CF;
                end
            end
            S_CF:
            begin
                mul_a      = cq_reg;
                mul_b      = px_reg;
                state_next = S_CU1;
            end
            S_CU1:
            begin
                net_next   = sat_sub64(sat_sub64(gross_reg, $signed({40'd0, cc_reg})),
                                       $signed({16'd0, share_reg}));
                oc_next    = oc_reg - share_reg;
                cash_next  = sat_add64(cash_reg, flow_s);
                state_next = S_CU2;
            end
            S_CU2:
            begin
                cash_next   = sat_sub64(cash_reg, $signed({40'd0, cc_reg}));
                pos_step    = sell_reg ? -$signed(cq_reg) : $signed(cq_reg);
                pos_next    = pos_reg + pos_step;
                left_next   = left_reg - cq_reg;
                if (pos_next == 0)
                begin
                    avg_next = '0;
                    oc_next  = '0;
                end
                pnl_next    = net_reg;
                closed_next = 1'b1;
                trades_next = trades_reg + 32'd1;
                if (net_reg > 0)
                    wins_next = wins_reg + 32'd1;
                state_next  = (left_next != 0) ? S_O0 : S_EQ;
            end
            // opening leg
            S_O0:
            begin
                pabs_next = pos_abs;
                oq_next   = (left_reg < room) ? left_reg : room;
                mul_a     = avg_reg;
                mul_b     = pos_abs;
                state_next = (oq_next != 0) ? S_O1 : S_OC;
            end
            S_O1:
            begin
                acc_next   = mul_p;
                mul_a      = px_reg;
                mul_b      = oq_reg;
                state_next = S_O2;
            end
            S_O2:
            begin
                div_req.start  = 1'b1;
                div_req.num_hi = '0;
                div_req.num_lo = acc_reg + mul_p;
                div_req.den    = 64'(pabs_reg) + 64'(oq_reg);
                acc_next       = mul_p;     // opening cash flow
                state_next     = S_ODW;
            end
            S_ODW:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quot[31:0];
                    pos_step   = sell_reg ? -$signed(oq_reg) : $signed(oq_reg);
                    pos_next   = pos_reg + pos_step;
                    cash_next  = sat_add64(cash_reg, sell_reg ? $signed(acc_reg)
                                                              : -$signed(acc_reg));
                    state_next = S_OC;
                end
            end
            S_OC:
            begin
                oc_next    = oc_sum[48] ? OC_MAX : oc_sum[47:0];
                cash_next  = sat_sub64(cash_reg, $signed({40'd0, oc_add}));
                state_next = S_EQ;
            end
            // mark to market
            S_EQ:
            begin
                mul_a      = pos_abs;
                mul_b      = last_reg;
                state_next = S_EQ2;
            end
            S_EQ2:
            begin
                eq_next    = sat_add64(cash_reg, pos_reg[31] ? -p_signed : p_signed);
                state_next = (cmd_reg == CMD_BAR) ? S_PK : S_DONE;
            end
            S_PK:
            begin
                if (eq_reg > peak_reg)
                    peak_next = eq_reg;
                state_next = S_PK2;
            end
            S_PK2:
            begin
                if (peak_reg > 0)
                begin
                    div_req.start  = 1'b1;
                    div_req.num_hi = drop >> (64 - DD_FRAC_BITS);
                    div_req.num_lo = drop << DD_FRAC_BITS;
                    div_req.den    = 64'(peak_reg);
                    state_next     = S_DDW;
                end
                else
                    state_next = S_DONE;
            end
            S_DDW:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quot > DD_LIM)
                    begin
                        if (DD_LIM[DD_FRAC_BITS-1:0] > dd_reg)
                            dd_next = DD_LIM[DD_FRAC_BITS-1:0];
                    end
                    else if (div_rsp.quot[DD_FRAC_BITS-1:0] > dd_reg)
                        dd_next = div_rsp.quot[DD_FRAC_BITS-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (o_load)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ov_reg     <= 1'b0;
            cash_reg   <= $signed({24'd0, INIT_CASH});
            peak_reg   <= $signed({24'd0, INIT_CASH});
            pos_reg    <= '0;
            avg_reg    <= '0;
            oc_reg     <= '0;
            last_reg   <= '0;
            dd_reg     <= '0;
            wins_reg   <= '0;
            trades_reg <= '0;
            held_reg   <= '0;
            seen_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ov_reg     <= ov_next;
            cash_reg   <= cash_next;
            peak_reg   <= peak_next;
            pos_reg    <= pos_next;
            avg_reg    <= avg_next;
            oc_reg     <= oc_next;
            last_reg   <= last_next;
            dd_reg     <= dd_next;
            wins_reg   <= wins_next;
            trades_reg <= trades_next;
            held_reg   <= held_next;
            seen_reg   <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        px_reg     <= px_next;
        qty_reg    <= qty_next;
        sell_reg   <= sell_next;
        comm_reg   <= comm_next;
        left_reg   <= left_next;
        cq_reg     <= cq_next;
        oq_reg     <= oq_next;
        pabs_reg   <= pabs_next;
        cc_reg     <= cc_next;
        share_reg  <= share_next;
        acc_reg    <= acc_next;
        gross_reg  <= gross_next;
        net_reg    <= net_next;
        eq_reg     <= eq_next;
        pnl_reg    <= pnl_next;
        closed_reg <= closed_next;
        if (state_reg == S_DONE && o_load)
        begin
            o_eq_reg     <= eq_reg;
            o_cash_reg   <= cash_reg;
            o_pos_reg    <= pos_reg;
            o_avg_reg    <= avg_reg;
            o_pnl_reg    <= pnl_reg;
            o_closed_reg <= closed_reg;
            o_dd_reg     <= dd_reg;
            o_wins_reg   <= wins_reg;
            o_trades_reg <= trades_reg;
            o_held_reg   <= held_reg;
            o_seen_reg   <= seen_reg;
        end
    end

    assign out_valid        = ov_reg;
    assign equity           = o_eq_reg;
    assign cash_now         = o_cash_reg;
    assign position_now     = o_pos_reg;
    assign entry_price      = o_avg_reg;
    assign realised_pnl     = o_pnl_reg;
    assign trade_closed     = o_closed_reg;
    assign drawdown_max     = o_dd_reg;
    assign wins             = o_wins_reg;
    assign closed_trades    = o_trades_reg;
    assign bars_in_position = o_held_reg;
    assign bars_total       = o_seen_reg;

    `PPT_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall)
    `PPT_ASSERT_NOW(a_div_idle, state_reg == S_IDLE, !div_rsp.busy)
    `PPT_ASSERT_NOW(a_pos_in_range, 1'b1, pos_reg != $signed(32'h8000_0000))

endmodule

>>> rtl/ppt_mul.sv
// ----------------------------------------------------------------------------
// ppt_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module ppt_mul
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;

endmodule

>>> rtl/ppt_div.sv
// ----------------------------------------------------------------------------
// ppt_div
// Radix-2 restoring divider, 128-bit dividend by 64-bit divisor. The quotient
// saturates to all ones when it would not fit in 64 bits.
// ----------------------------------------------------------------------------
module ppt_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppt_pkg::ppt_div_req_t req,
    output ppt_pkg::ppt_div_rsp_t rsp
);
    import ppt_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [63:0]          rem_reg;
    logic [63:0]          sh_reg;
    logic [63:0]          den_reg;
    logic [63:0]          quot_reg;

    logic [64:0] trial;
    logic        ge;

    assign trial = {rem_reg, sh_reg[63]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (req.num_hi >= req.den)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.num_hi;
            sh_reg   <= req.num_lo;
            den_reg  <= req.den;
            quot_reg <= '1;     // kept on overflow
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? 64'(trial - {1'b0, den_reg}) : trial[63:0];
            sh_reg   <= {sh_reg[62:0], 1'b0};
            quot_reg <= {quot_reg[62:0], ge};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for position_pnl_tracker. Bars, ticks and fills are
// driven through the stall handshake, a bit-true model of the average-cost
// book predicts every result beat, and a monitor compares them field by
// field. Covers the position limit, saturation, initial cash settings,
// output back-pressure and random traffic.
// ----------------------------------------------------------------------------
module testbench;
    import ppt_pkg::*;

    localparam logic [1:0] CMD_NONE  = 2'd3;
    localparam int         LIMIT     = 3_000_000;
    localparam int         SETTLE    = 300;
    localparam longint unsigned LOT_MAX  = 64'hFF_FFFF;
    localparam longint unsigned POS_MAX  = 64'h7FFF_FFFF;
    localparam longint unsigned OC_CAP   = 64'hFFFF_FFFF_FFFF;
    localparam longint          I64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint          I64_MIN  = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic signed [63:0] equity;
        logic signed [63:0] cash;
        logic signed [31:0] pos;
        logic [31:0]        entry;
        logic signed [63:0] pnl;
        logic               closed;
        logic [15:0]        dd;
        logic [31:0]        wins;
        logic [31:0]        trades;
        logic [31:0]        held;
        logic [31:0]        bars;
    } book_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [39:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] command = '0;
    logic [31:0] price = '0;
    logic [23:0] quantity = '0;
    logic side = 1'b0;
    logic [23:0] commission = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [63:0] equity, cash_now, realised_pnl;
    logic signed [31:0] position_now;
    logic [31:0] entry_price, wins, closed_trades, bars_in_position, bars_total;
    logic trade_closed;
    logic [15:0] drawdown_max;

    // book model state
    longint          bk_cash, bk_pos, bk_peak;
    longint unsigned bk_avg, bk_oc, bk_last;
    logic [15:0]     bk_dd;
    int unsigned     bk_wins, bk_trades, bk_held, bk_bars;

    book_rec_t pending_q[$];
    int errors = 0;
    int cycles = 0;
    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;
    longint unsigned base_px = 100000;

    position_pnl_tracker u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .command(command), .price(price),
        .quantity(quantity), .side(side), .commission(commission),
        .out_valid(out_valid), .out_stall(out_stall), .equity(equity),
        .cash_now(cash_now), .position_now(position_now), .entry_price(entry_price),
        .realised_pnl(realised_pnl), .trade_closed(trade_closed),
        .drawdown_max(drawdown_max), .wins(wins), .closed_trades(closed_trades),
        .bars_in_position(bars_in_position), .bars_total(bars_total)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint clamp_add(longint a, longint b);
        if (b > 0 && a > I64_MAX - b) return I64_MAX;
        if (b < 0 && a < I64_MIN - b) return I64_MIN;
        return a + b;
    endfunction

    function automatic longint clamp_sub(longint a, longint b);
        if (b < 0 && a > I64_MAX + b) return I64_MAX;
        if (b > 0 && a < I64_MIN + b) return I64_MIN;
        return a - b;
    endfunction

    // floor(a*b/c) on a 128-bit product, all-ones when it overflows 64 bits
    function automatic longint unsigned scaled_quot(longint unsigned a, longint unsigned b,
                                                    longint unsigned c);
        logic [127:0] prod;
        logic [127:0] q;
        prod = {64'd0, a} * {64'd0, b};
        q = prod / {64'd0, c};
        return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    function automatic longint marked_equity();
        return clamp_add(bk_cash, bk_pos * longint'(bk_last));
    endfunction

    function automatic void book_reset();
        bk_cash = 1000000000;
        bk_peak = 1000000000;
        bk_pos = 0;
        bk_avg = 0;
        bk_oc = 0;
        bk_last = 0;
        bk_dd = 0;
        bk_wins = 0;
        bk_trades = 0;
        bk_held = 0;
        bk_bars = 0;
    endfunction

    function automatic void book_fill(longint unsigned px, longint unsigned qty, bit sell,
                                      longint unsigned comm, ref longint pnl, ref bit closed);
        longint unsigned left, cc, pa, cq, sh, room, oq, oc;
        longint diff, gross, net, flow;
        left = qty;
        cc = 0;
        if (qty == 0) return;
        if ((bk_pos > 0 && sell) || (bk_pos < 0 && !sell))
        begin
            pa = (bk_pos > 0) ? bk_pos : -bk_pos;
            cq = (pa < left) ? pa : left;
            diff = longint'(px) - longint'(bk_avg);
            gross = diff * longint'(cq);
            if (bk_pos < 0) gross = -gross;
            cc = scaled_quot(comm, cq, qty);
            sh = scaled_quot(bk_oc, cq, pa);
            net = clamp_sub(clamp_sub(gross, longint'(cc)), longint'(sh));
            bk_oc = bk_oc - sh;
            flow = longint'(cq * px);
            bk_cash = clamp_add(bk_cash, sell ? flow : -flow);
            bk_cash = clamp_sub(bk_cash, longint'(cc));
            bk_pos = bk_pos + (sell ? -longint'(cq) : longint'(cq));
            left = left - cq;
            if (bk_pos == 0)
            begin
                bk_avg = 0;
                bk_oc = 0;
            end
            pnl = net;
            closed = 1'b1;
            bk_trades++;
            if (net > 0) bk_wins++;
        end
        if (left > 0)
        begin
            pa = (bk_pos > 0) ? bk_pos : -bk_pos;
            room = POS_MAX - pa;
            oq = (left < room) ? left : room;
            oc = comm - cc;
            if (oq > 0)
            begin
                flow = longint'(oq * px);
                bk_avg = (bk_avg * pa + px * oq) / (pa + oq);
                bk_pos = bk_pos + (sell ? -longint'(oq) : longint'(oq));
                bk_cash = clamp_add(bk_cash, sell ? flow : -flow);
            end
            bk_oc = (bk_oc > OC_CAP - oc) ? OC_CAP : bk_oc + oc;
            bk_cash = clamp_sub(bk_cash, longint'(oc));
        end
    endfunction

    function automatic void book_bar(longint unsigned px);
        longint eq;
        longint unsigned drop, dd;
        bk_last = px;
        bk_bars++;
        if (bk_pos != 0) bk_held++;
        eq = marked_equity();
        if (eq > bk_peak) bk_peak = eq;
        if (bk_peak > 0)
        begin
            drop = longint'(bk_peak) - eq;
            dd = scaled_quot(drop, 64'd65536, bk_peak);
            if (dd > 65535) dd = 65535;
            if (dd > bk_dd) bk_dd = dd[15:0];
        end
    endfunction

    function automatic book_rec_t book_step(logic [1:0] cmd, logic [31:0] px, logic [23:0] qty,
                                            logic sd, logic [23:0] comm);
        book_rec_t r;
        longint pnl;
        bit closed;
        pnl = 0;
        closed = 1'b0;
        case (cmd)
            CMD_BAR:  book_bar(px);
            CMD_TICK: bk_last = px;
            CMD_FILL: book_fill(px, qty, sd, comm, pnl, closed);
            default: ;
        endcase
        r.equity = marked_equity();
        r.cash = bk_cash;
        r.pos = bk_pos[31:0];
        r.entry = bk_avg[31:0];
        r.pnl = pnl;
        r.closed = closed;
        r.dd = bk_dd;
        r.wins = bk_wins;
        r.trades = bk_trades;
        r.held = bk_held;
        r.bars = bk_bars;
        return r;
    endfunction

    // one beat in; leaves in_valid high unless a random gap follows, so back-to-back beats need no toggle
    task automatic send_item(logic [1:0] cmd, logic [31:0] px, logic [23:0] qty,
                             logic sd, logic [23:0] comm);
        in_valid <= 1'b1;
        command <= cmd;
        price <= px;
        quantity <= qty;
        side <= sd;
        commission <= comm;
        do @(posedge clk); while (in_stall);
        pending_q.insert(pending_q.size(), book_step(cmd, px, qty, sd, comm));
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_cash(logic [39:0] v);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        bk_cash = longint'({24'd0, v});
        bk_peak = bk_cash;
    endtask

    function automatic logic [31:0] pick_price();
        if ($urandom_range(0, 19) == 0) return $urandom;
        if ($urandom_range(0, 9) == 0)
            base_px = $urandom_range(1000, 5000000);
        base_px = base_px + $urandom_range(0, 2000) - 1000;
        if (base_px < 1000 || base_px > 64'hFFFF_FFFF) base_px = 100000;
        return base_px[31:0];
    endfunction

    task automatic random_item();
        int k;
        logic [23:0] qty, comm;
        logic [1:0] cmd;
        k = $urandom_range(0, 99);
        cmd = (k < 42) ? CMD_FILL : (k < 78) ? CMD_BAR : (k < 95) ? CMD_TICK : CMD_NONE;
        k = $urandom_range(0, 49);
        qty = (k == 0) ? 24'd0 : (k < 4) ? 24'($urandom) : 24'($urandom_range(1, 1000));
        comm = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 5000));
        send_item(cmd, pick_price(), qty, 1'($urandom), comm);
    endtask

    task automatic test_basics();
        send_item(CMD_BAR, 32'd0, 24'd1, 1'b0, 24'd0);
        send_item(CMD_TICK, 32'd150000, 24'd1, 1'b0, 24'd0);
        send_item(CMD_NONE, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1, 24'hFF_FFFF);
        send_item(CMD_FILL, 32'd100000, 24'd0, 1'b0, 24'd500);    // zero lots: no effect
        send_item(CMD_FILL, 32'd100000, 24'd100, 1'b0, 24'd1000);
        send_item(CMD_FILL, 32'd103333, 24'd50, 1'b0, 24'd777);
        send_item(CMD_BAR, 32'd90000, 24'd1, 1'b0, 24'd0);
        send_item(CMD_FILL, 32'd120000, 24'd30, 1'b1, 24'd301);   // partial close, win
        send_item(CMD_FILL, 32'd80000, 24'd200, 1'b1, 24'hFF_FFFF); // close and flip short
        send_item(CMD_BAR, 32'hFFFF_FFFF, 24'd1, 1'b0, 24'd0);
        send_item(CMD_FILL, 32'd70000, 24'd80, 1'b0, 24'd0);      // full close of short
        send_item(CMD_FILL, 32'hFFFF_FFFF, 24'd1, 1'b1, 24'd1);
        send_item(CMD_FILL, 32'd0, 24'd1, 1'b0, 24'd0);
        send_item(CMD_TICK, 32'hFFFF_FFFF, 24'd0, 1'b1, 24'hFF_FFFF);
        send_item(CMD_BAR, 32'd1, 24'hAAAAAA, 1'b1, 24'h555555);
        send_item(CMD_FILL, 32'h5555_5555, 24'h555555, 1'b1, 24'hAAAAAA);
        send_item(CMD_FILL, 32'hAAAA_AAAA, 24'hAAAAAA, 1'b0, 24'h555555);
        send_item(CMD_BAR, 32'd100000, 24'd1, 1'b0, 24'd0);
    endtask

    // drive the book into the lot cap at the top price, then flatten it
    task automatic test_position_cap();
        longint unsigned q;
        repeat (130) send_item(CMD_FILL, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, 24'hFF_FFFF);
        send_item(CMD_BAR, 32'hFFFF_FFFF, 24'd1, 1'b0, 24'd0);
        send_item(CMD_TICK, 32'd1, 24'd1, 1'b0, 24'd0);
        while (bk_pos != 0)
        begin
            q = (bk_pos > 0) ? bk_pos : -bk_pos;
            if (q > LOT_MAX) q = LOT_MAX;
            send_item(CMD_FILL, 32'd2, q[23:0], bk_pos > 0, 24'd3);
        end
        send_item(CMD_BAR, 32'd2, 24'd1, 1'b0, 24'd0);
    endtask

    task automatic test_cash_settings();
        write_cash(40'd0);
        send_item(CMD_BAR, 32'd100, 24'd1, 1'b0, 24'd0);
        send_item(CMD_FILL, 32'd100, 24'd10, 1'b0, 24'd5);
        send_item(CMD_BAR, 32'd50, 24'd1, 1'b0, 24'd0);           // zero peak: no drawdown
        write_cash(40'hFF_FFFF_FFFF);
        repeat (20) random_item();
        write_cash(40'($urandom_range(1, 1000)));
        send_item(CMD_BAR, 32'd0, 24'd1, 1'b0, 24'd0);
        send_item(CMD_BAR, 32'hFFFF_FFFF, 24'd1, 1'b0, 24'd0);
        repeat (20) random_item();
        write_cash(40'd1000000000);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (12) random_item();
        drain();
        repeat (30) random_item();
    endtask

    task automatic test_random(int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            if (i % 300 == 299) write_cash({$urandom, 8'($urandom)});
            if (i == n - 200) gaps_on = 1'b0;
            random_item();
        end
    endtask

    // output stall: short random bursts, one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (800) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, longint unsigned exp, longint unsigned got);
        if (exp !== got)
        begin
            $error("%s: expected %0h, got %0h", name, exp, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        book_rec_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result beat with nothing pending");
                errors++;
            end
            else
            begin
                e = pending_q[0];
                pending_q.delete(0);
                check_field("equity", e.equity, equity);
                check_field("cash_now", e.cash, cash_now);
                check_field("position_now", {32'd0, e.pos}, {32'd0, position_now});
                check_field("entry_price", e.entry, entry_price);
                check_field("realised_pnl", e.pnl, realised_pnl);
                check_field("trade_closed", e.closed, trade_closed);
                check_field("drawdown_max", e.dd, drawdown_max);
                check_field("wins", e.wins, wins);
                check_field("closed_trades", e.trades, closed_trades);
                check_field("bars_in_position", e.held, bars_in_position);
                check_field("bars_total", e.bars, bars_total);
            end
        end
    end

    initial
    begin
        book_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basics();
        test_position_cap();
        test_cash_settings();
        test_backpressure();
        test_random(900);
        drain();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ppt_pkg.sv
rtl/ppt_mul.sv
rtl/ppt_div.sv
rtl/position_pnl_tracker.sv
dv/testbench.sv
